// File: hdl/rtt_pkg.sv
// shared types, codes and character classes of the rule text tokenizer
package rtt_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int RUN_MAX         = 3;
    localparam int RUN_CNT_W       = $clog2(RUN_MAX + 1);
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [4:0] CODE_END    = 5'd0;
    localparam logic [4:0] CODE_IDENT  = 5'd1;
    localparam logic [4:0] CODE_NUMBER = 5'd2;
    localparam logic [4:0] CODE_STRING = 5'd3;
    localparam logic [4:0] CODE_LBRACE = 5'd4;
    localparam logic [4:0] CODE_RBRACE = 5'd5;
    localparam logic [4:0] CODE_LPAREN = 5'd6;
    localparam logic [4:0] CODE_RPAREN = 5'd7;
    localparam logic [4:0] CODE_COMMA  = 5'd8;
    localparam logic [4:0] CODE_EQUAL  = 5'd9;
    localparam logic [4:0] CODE_SEMI   = 5'd10;
    localparam logic [4:0] CODE_DOT    = 5'd11;
    localparam logic [4:0] CODE_PLUS   = 5'd12;
    localparam logic [4:0] CODE_MINUS  = 5'd13;
    localparam logic [4:0] CODE_STAR   = 5'd14;
    localparam logic [4:0] CODE_SLASH  = 5'd15;
    localparam logic [4:0] CODE_BYTE   = 5'd16;
    localparam logic [4:0] CODE_ERROR  = 5'd17;

    localparam logic [1:0] ERR_BAD_CHAR    = 2'd0;
    localparam logic [1:0] ERR_OPEN_STRING = 2'd1;
    localparam logic [1:0] ERR_OPEN_ESCAPE = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG    = 2'd3;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [4:0]         code;
        logic [FIELD_W-1:0] offset;
        logic [FIELD_W-1:0] length;
        logic [7:0]         value_byte;
        logic [1:0]         error_kind;
    } rtt_result_t;

    typedef struct packed {
        rtt_result_t [RUN_MAX-1:0] item;
        logic [RUN_CNT_W-1:0]      count;
    } rtt_run_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // CODE_END when the byte is no single-byte punctuation
    function automatic logic [4:0] punct_code(input logic [7:0] c);
        logic [4:0] p;
        unique case (c)
            CH_LBRACE: p = CODE_LBRACE;
            CH_RBRACE: p = CODE_RBRACE;
            CH_LPAREN: p = CODE_LPAREN;
            CH_RPAREN: p = CODE_RPAREN;
            CH_COMMA:  p = CODE_COMMA;
            CH_EQUAL:  p = CODE_EQUAL;
            CH_SEMI:   p = CODE_SEMI;
            CH_DOT:    p = CODE_DOT;
            CH_PLUS:   p = CODE_PLUS;
            CH_STAR:   p = CODE_STAR;
            default:   p = CODE_END;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] d;
        unique case (c)
            CH_LC_N: d = CH_LF;
            CH_LC_T: d = CH_TAB;
            CH_LC_R: d = CH_CR;
            default: d = c;
        endcase
        return d;
    endfunction

    function automatic rtt_result_t make_result(
        input logic [4:0]         code,
        input logic [FIELD_W-1:0] offset,
        input logic [FIELD_W-1:0] length,
        input logic [7:0]         value_byte,
        input logic [1:0]         error_kind
    );
        rtt_result_t r;
        r.code       = code;
        r.offset     = offset;
        r.length     = length;
        r.value_byte = value_byte;
        r.error_kind = error_kind;
        return r;
    endfunction

endpackage

// File: hdl/rtt_front.sv
// front end: lexer state and classification of each byte into a run of results
module rtt_front import rtt_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_take,
    input  logic [7:0] character,
    input  logic       has_character,
    input  logic       end_of_text,
    output logic       run_push,
    output rtt_run_t   run
);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_COMMENT = 4'd1;
    localparam logic [3:0] M_MINUS   = 4'd2;
    localparam logic [3:0] M_SLASH   = 4'd3;
    localparam logic [3:0] M_IDENT   = 4'd4;
    localparam logic [3:0] M_INT     = 4'd5;
    localparam logic [3:0] M_FRAC    = 4'd6;
    localparam logic [3:0] M_STR     = 4'd7;
    localparam logic [3:0] M_ESC     = 4'd8;
    localparam logic [3:0] M_ERROR   = 4'd9;

    localparam logic [OFFSET_BITS-1:0] MAX_OFF = '1;
    localparam logic [FIELD_W-1:0]     ONE_LEN = FIELD_W'(1);
    localparam logic [FIELD_W-1:0]     NO_LEN  = '0;

    logic [3:0]             mode_reg, mode_next, mode_mid;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next, pos_mid;
    logic [OFFSET_BITS-1:0] ts_reg, ts_next, ts_mid;
    logic [OFFSET_BITS-1:0] tc_reg, tc_next, tc_mid;
    logic                   restart;
    logic [4:0]             pcode;
    logic [3:0]             cand_v;
    rtt_result_t [3:0]      cand;
    logic [RUN_CNT_W-1:0]   n;

    assign pcode = punct_code(character);

    always_comb begin
        mode_mid = mode_reg;
        pos_mid  = pos_reg;
        ts_mid   = ts_reg;
        tc_mid   = tc_reg;
        restart  = 1'b0;
        cand_v   = '0;
        cand     = '0;

        // byte of the item
        if (has_character && (mode_reg != M_ERROR)) begin
            if (pos_reg == MAX_OFF) begin
                cand_v[0] = 1'b1;
                cand[0]   = make_result(CODE_ERROR, FIELD_W'(pos_reg), NO_LEN, 8'd0,
                                        ERR_TOO_LONG);
                mode_mid  = M_ERROR;
            end else begin
                pos_mid = pos_reg + 1'b1;
                unique case (mode_reg)
                    M_COMMENT: begin
                        if (character == CH_LF) begin
                            mode_mid = M_IDLE;
                        end
                    end
                    M_MINUS: begin
                        if (is_digit(character)) begin
                            mode_mid = M_INT;
                        end else begin
                            cand_v[0] = 1'b1;
                            cand[0]   = make_result(CODE_MINUS, FIELD_W'(ts_reg), ONE_LEN,
                                                    8'd0, ERR_BAD_CHAR);
                            restart   = 1'b1;
                        end
                    end
                    M_SLASH: begin
                        if (character == CH_SLASH) begin
                            mode_mid = M_COMMENT;
                        end else begin
                            cand_v[0] = 1'b1;
                            cand[0]   = make_result(CODE_SLASH, FIELD_W'(ts_reg), ONE_LEN,
                                                    8'd0, ERR_BAD_CHAR);
                            restart   = 1'b1;
                        end
                    end
                    M_IDENT: begin
                        if (!(is_alpha(character) || is_digit(character) ||
                              (character == CH_UNDER) || (character == CH_MINUS))) begin
                            cand_v[0] = 1'b1;
                            cand[0]   = make_result(CODE_IDENT, FIELD_W'(ts_reg),
                                                    FIELD_W'(pos_reg - ts_reg), 8'd0,
                                                    ERR_BAD_CHAR);
                            restart   = 1'b1;
                        end
                    end
                    M_INT: begin
                        if (character == CH_DOT) begin
                            mode_mid = M_FRAC;
                        end else if (!is_digit(character)) begin
                            cand_v[0] = 1'b1;
                            cand[0]   = make_result(CODE_NUMBER, FIELD_W'(ts_reg),
                                                    FIELD_W'(pos_reg - ts_reg), 8'd0,
                                                    ERR_BAD_CHAR);
                            restart   = 1'b1;
                        end
                    end
                    M_FRAC: begin
                        if (!is_digit(character)) begin
                            cand_v[0] = 1'b1;
                            cand[0]   = make_result(CODE_NUMBER, FIELD_W'(ts_reg),
                                                    FIELD_W'(pos_reg - ts_reg), 8'd0,
                                                    ERR_BAD_CHAR);
                            restart   = 1'b1;
                        end
                    end
                    M_STR: begin
                        priority if (character == CH_QUOTE) begin
                            cand_v[0] = 1'b1;
                            cand[0]   = make_result(CODE_STRING, FIELD_W'(ts_reg),
                                                    FIELD_W'(tc_reg), 8'd0, ERR_BAD_CHAR);
                            mode_mid  = M_IDLE;
                        end else if (character == CH_BSLASH) begin
                            mode_mid = M_ESC;
                        end else begin
                            tc_mid    = tc_reg + 1'b1;
                            cand_v[0] = 1'b1;
                            cand[0]   = make_result(CODE_BYTE, FIELD_W'(ts_reg),
                                                    FIELD_W'(tc_mid), character, ERR_BAD_CHAR);
                        end
                    end
                    M_ESC: begin
                        tc_mid    = tc_reg + 1'b1;
                        cand_v[0] = 1'b1;
                        cand[0]   = make_result(CODE_BYTE, FIELD_W'(ts_reg), FIELD_W'(tc_mid),
                                                unescape(character), ERR_BAD_CHAR);
                        mode_mid  = M_STR;
                    end
                    M_ERROR: begin
                    end
                    default: begin
                        restart = 1'b1;
                    end
                endcase

                // byte opens a new token
                if (restart) begin
                    mode_mid = M_IDLE;
                    priority if (is_space(character)) begin
                    end else if (pcode != CODE_END) begin
                        cand_v[1] = 1'b1;
                        cand[1]   = make_result(pcode, FIELD_W'(pos_reg), ONE_LEN, 8'd0,
                                                ERR_BAD_CHAR);
                    end else begin
                        ts_mid = pos_reg;
                        priority if (character == CH_HASH) begin
                            mode_mid = M_COMMENT;
                        end else if (character == CH_SLASH) begin
                            mode_mid = M_SLASH;
                        end else if (character == CH_MINUS) begin
                            mode_mid = M_MINUS;
                        end else if (character == CH_QUOTE) begin
                            mode_mid = M_STR;
                            tc_mid   = '0;
                        end else if (is_alpha(character) || (character == CH_UNDER)) begin
                            mode_mid = M_IDENT;
                        end else if (is_digit(character)) begin
                            mode_mid = M_INT;
                        end else begin
                            cand_v[1] = 1'b1;
                            cand[1]   = make_result(CODE_ERROR, FIELD_W'(pos_reg), NO_LEN,
                                                    8'd0, ERR_BAD_CHAR);
                            mode_mid  = M_ERROR;
                        end
                    end
                end
            end
        end

        // end of text
        if (end_of_text) begin
            unique case (mode_mid)
                M_MINUS: begin
                    cand_v[2] = 1'b1;
                    cand[2]   = make_result(CODE_MINUS, FIELD_W'(ts_mid), ONE_LEN, 8'd0,
                                            ERR_BAD_CHAR);
                end
                M_SLASH: begin
                    cand_v[2] = 1'b1;
                    cand[2]   = make_result(CODE_SLASH, FIELD_W'(ts_mid), ONE_LEN, 8'd0,
                                            ERR_BAD_CHAR);
                end
                M_IDENT: begin
                    cand_v[2] = 1'b1;
                    cand[2]   = make_result(CODE_IDENT, FIELD_W'(ts_mid),
                                            FIELD_W'(pos_mid - ts_mid), 8'd0, ERR_BAD_CHAR);
                end
                M_INT, M_FRAC: begin
                    cand_v[2] = 1'b1;
                    cand[2]   = make_result(CODE_NUMBER, FIELD_W'(ts_mid),
                                            FIELD_W'(pos_mid - ts_mid), 8'd0, ERR_BAD_CHAR);
                end
                M_STR: begin
                    cand_v[2] = 1'b1;
                    cand[2]   = make_result(CODE_ERROR, FIELD_W'(ts_mid), NO_LEN, 8'd0,
                                            ERR_OPEN_STRING);
                end
                M_ESC: begin
                    cand_v[2] = 1'b1;
                    cand[2]   = make_result(CODE_ERROR, FIELD_W'(ts_mid), NO_LEN, 8'd0,
                                            ERR_OPEN_ESCAPE);
                end
                default: begin
                end
            endcase
            if ((mode_mid != M_ERROR) && (mode_mid != M_STR) && (mode_mid != M_ESC)) begin
                cand_v[3] = 1'b1;
                cand[3]   = make_result(CODE_END, FIELD_W'(pos_mid), NO_LEN, 8'd0,
                                        ERR_BAD_CHAR);
            end
            mode_next = M_IDLE;
            pos_next  = '0;
            ts_next   = '0;
            tc_next   = '0;
        end else begin
            mode_next = mode_mid;
            pos_next  = pos_mid;
            ts_next   = ts_mid;
            tc_next   = tc_mid;
        end

        // pack the results in order, at most three per byte
        n   = '0;
        run = '0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i]) begin
                run.item[n] = cand[i];
                n           = n + 1'b1;
            end
        end
        run.count = n;
    end

    assign run_push = in_take && (n != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            pos_reg  <= '0;
            ts_reg   <= '0;
            tc_reg   <= '0;
        end else if (in_take) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            ts_reg   <= ts_next;
            tc_reg   <= tc_next;
        end
    end

endmodule

// File: hdl/rtt_queue.sv
// short queue of result runs between front and back end
module rtt_queue import rtt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  rtt_run_t push_data,
    output logic     full,
    input  logic     pop,
    output rtt_run_t pop_data,
    output logic     empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

    rtt_run_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   fill_reg, fill_next;

    assign full     = (fill_reg == DEPTH_CNT);
    assign empty    = (fill_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/rtt_back.sv
// back end: output register that hands out the results of a run one at a time
module rtt_back import rtt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  rtt_run_t           run,
    input  logic               run_empty,
    output logic               run_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_code,
    output logic [FIELD_W-1:0] m_offset,
    output logic [FIELD_W-1:0] m_length,
    output logic [7:0]         m_value_byte,
    output logic [1:0]         m_error_kind,
    output logic               m_last_of_run
);

    rtt_run_t             cur_reg;
    logic [RUN_CNT_W-1:0] idx_reg;
    logic                 valid_reg;
    logic                 last;
    logic                 done;
    rtt_result_t          sel;

    assign last    = (idx_reg == (cur_reg.count - 1'b1));
    assign done    = valid_reg && m_ready && last;
    assign run_pop = !run_empty && (!valid_reg || done);
    assign sel     = cur_reg.item[idx_reg];

    assign m_valid       = valid_reg;
    assign m_code        = sel.code;
    assign m_offset      = sel.offset;
    assign m_length      = sel.length;
    assign m_value_byte  = sel.value_byte;
    assign m_error_kind  = sel.error_kind;
    assign m_last_of_run = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (run_pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (done) begin
            valid_reg <= 1'b0;
        end else if (valid_reg && m_ready) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (run_pop) begin
            cur_reg <= run;
        end
    end

endmodule

// File: hdl/rule_text_tokenizer.sv
// top level of the rule text tokenizer
//
// s_ channel: one byte of rule text per request (s_character with s_has_character),
// s_end_of_text closes the text after the byte of the same request.
// m_ channel: one token, decoded string byte, end marker or error per request;
// m_last_of_run marks the last result caused by one input byte.
// path: with the output idle, the results of an accepted byte are written to the queue
// and then loaded into the output register, which raises m_valid for the first of them.
// throughput: one byte per cycle while each byte gives at most one result and the
// receiver does not stall; a byte with more results holds the output for each one,
// and the front keeps taking bytes until its four-run queue is full.
// reset: lexer returns to idle with offset zero, queue and output register empty.
// when the receiver stalls the result holds, the queue fills, then s_ready falls.
// after an error the rest of the text is swallowed up to end of text.
module rule_text_tokenizer import rtt_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_character,
    input  logic               s_has_character,
    input  logic               s_end_of_text,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_code,
    output logic [FIELD_W-1:0] m_offset,
    output logic [FIELD_W-1:0] m_length,
    output logic [7:0]         m_value_byte,
    output logic [1:0]         m_error_kind,
    output logic               m_last_of_run
);

    logic     q_full, q_empty, q_push, q_pop;
    logic     take;
    rtt_run_t front_run, back_run;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    rtt_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_take      (take),
        .character    (s_character),
        .has_character(s_has_character),
        .end_of_text  (s_end_of_text),
        .run_push     (q_push),
        .run          (front_run)
    );

    rtt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(front_run),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (back_run),
        .empty    (q_empty)
    );

    rtt_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .run          (back_run),
        .run_empty    (q_empty),
        .run_pop      (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code       (m_code),
        .m_offset     (m_offset),
        .m_length     (m_length),
        .m_value_byte (m_value_byte),
        .m_error_kind (m_error_kind),
        .m_last_of_run(m_last_of_run)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("run pushed into a full queue");

    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_code == CODE_ERROR)) |-> m_last_of_run)
        else $error("result follows an error in the same run");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_code == CODE_END)) |-> m_last_of_run)
        else $error("result follows end of text in the same run");

    a_value_only_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_code != CODE_BYTE)) |-> (m_value_byte == 8'd0))
        else $error("value byte set on a result that is no string byte");
`endif

endmodule
